@@ src/gws_pkg.sv @@
// shared types and constants for the grid row and column word search unit
`default_nettype none

package gws_pkg;

    localparam int GRID_SIDE_DEF = 8;
    localparam int CHAR_W        = 8;
    localparam int OPCODE_W      = 2;
    localparam int COORD_W       = 3;
    localparam int LEN_W         = 4;

    localparam logic [OPCODE_W-1:0] OP_LOAD_GRID = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_PAT  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SEARCH    = 2'd2;

    typedef logic [CHAR_W-1:0] char_t;

    // per-cell controls from the sequencer
    typedef struct packed {
        logic wr_en;
        logic shift_v;
        logic shift_h;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROWS = 4'b0010,
        S_COLS = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

endpackage

`default_nettype wire

@@ src/gws_column_cell.sv @@
// one grid column cell: holds a column, rotates it vertically or passes it to its neighbor
`default_nettype none

module gws_column_cell #(
    parameter int GRID_SIDE = gws_pkg::GRID_SIDE_DEF
) (
    input  logic                                clk,
    input  gws_pkg::cell_ctrl_t                 ctrl,
    input  logic [$clog2(GRID_SIDE)-1:0]        wr_row,
    input  gws_pkg::char_t                      wr_data,
    input  gws_pkg::char_t [GRID_SIDE-1:0]      col_in,
    output gws_pkg::char_t [GRID_SIDE-1:0]      col_out
);
    import gws_pkg::*;

    char_t [GRID_SIDE-1:0] col_reg;
    char_t [GRID_SIDE-1:0] col_next;

    always_comb
    begin
        col_next = col_reg;
        if (ctrl.shift_h)
        begin
            // whole column moves one cell down the chain
            col_next = col_in;
        end
        else if (ctrl.shift_v)
        begin
            // rotate up so entry zero holds the next row
            for (int i = 0; i < GRID_SIDE; i++)
            begin
                col_next[i] = col_reg[(i + 1) % GRID_SIDE];
            end
        end
        else if (ctrl.wr_en)
        begin
            col_next[wr_row] = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

@@ src/gws_line_matcher.sv @@
// tests one grid line against the pattern at every start offset
`default_nettype none

module gws_line_matcher #(
    parameter int GRID_SIDE = gws_pkg::GRID_SIDE_DEF
) (
    input  gws_pkg::char_t [GRID_SIDE-1:0]      line,
    input  gws_pkg::char_t [GRID_SIDE-1:0]      pat,
    input  logic [gws_pkg::LEN_W-1:0]           len,
    output logic                                hit
);
    import gws_pkg::*;

    always_comb
    begin
        int  len_i;
        logic ok;
        len_i = 32'(len);
        hit   = 1'b0;
        for (int s = 0; s < GRID_SIDE; s++)
        begin
            // a run that would pass the end of the line is already ruled out here
            ok = (s + len_i <= GRID_SIDE);
            for (int k = 0; k < GRID_SIDE - s; k++)
            begin
                if ((k < len_i) && (line[s + k] != pat[k]))
                begin
                    ok = 1'b0;
                end
            end
            hit = hit | ok;
        end
    end

endmodule

`default_nettype wire

@@ src/grid_row_column_word_search_unit.sv @@
// top level: command port, pattern store, column cell chain and scan sequencer
//
//   channel | signals                                          | carries
//   cmd     | cmd_valid, cmd_ready, opcode, row, col,          | loads and searches
//           | char_value, pattern_length                       |
//   res     | res_valid, res_ready, found                      | one flag per search
//
// loads write the grid cells or the pattern store; in a search the cell chain
// presents one row per cycle by vertical rotation, then one column per cycle by
// rotating columns along the chain, and the hold state hands the flag to the output
// register. cmd_ready is high only while no search is running. a finished result
// waits in the output register; loads and a new search are taken meanwhile, and a
// search that finishes before the previous flag is taken holds until it is.
// reset clears control state only; grid and pattern contents are undefined until loaded.
`default_nettype none

module grid_row_column_word_search_unit #(
    parameter int GRID_SIDE = gws_pkg::GRID_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [gws_pkg::OPCODE_W-1:0]        opcode,
    input  logic [gws_pkg::COORD_W-1:0]         row,
    input  logic [gws_pkg::COORD_W-1:0]         col,
    input  logic [gws_pkg::CHAR_W-1:0]          char_value,
    input  logic [gws_pkg::LEN_W-1:0]           pattern_length,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic                                found
);
    import gws_pkg::*;

    localparam int                IDX_W    = $clog2(GRID_SIDE);
    localparam logic [IDX_W-1:0]  CNT_LAST = IDX_W'(GRID_SIDE - 1);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   hit_reg, hit_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   found_reg, found_next;
    char_t [GRID_SIDE-1:0]  pat_reg, pat_next;

    logic                   cmd_fire;
    logic                   row_ok, col_ok;
    logic [IDX_W-1:0]       row_idx, col_idx;
    logic                   line_hit;
    char_t [GRID_SIDE-1:0]  line;
    char_t [GRID_SIDE-1:0]  col_data [GRID_SIDE];
    cell_ctrl_t             cell_ctrl [GRID_SIDE];

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign row_ok    = (32'(row) < GRID_SIDE);
    assign col_ok    = (32'(col) < GRID_SIDE);
    assign row_idx   = IDX_W'(row);
    assign col_idx   = IDX_W'(col);

    // column cells, chained so each takes its right neighbor's column
    for (genvar c = 0; c < GRID_SIDE; c++)
    begin : g_cell
        assign cell_ctrl[c].wr_en   = cmd_fire && (opcode == OP_LOAD_GRID) && row_ok
                                      && col_ok && (32'(col) == c);
        assign cell_ctrl[c].shift_v = (state_reg == S_ROWS);
        assign cell_ctrl[c].shift_h = (state_reg == S_COLS);

        gws_column_cell #(
            .GRID_SIDE (GRID_SIDE)
        ) u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl[c]),
            .wr_row  (row_idx),
            .wr_data (char_value),
            .col_in  (col_data[(c + 1) % GRID_SIDE]),
            .col_out (col_data[c])
        );
    end

    // row scan reads the top entry of every cell, column scan reads the first cell
    always_comb
    begin
        for (int c = 0; c < GRID_SIDE; c++)
        begin
            line[c] = col_data[c][0];
        end
        if (state_reg == S_COLS)
        begin
            line = col_data[0];
        end
    end

    gws_line_matcher #(
        .GRID_SIDE (GRID_SIDE)
    ) u_matcher (
        .line (line),
        .pat  (pat_reg),
        .len  (len_reg),
        .hit  (line_hit)
    );

    always_comb
    begin
        pat_next = pat_reg;
        if (cmd_fire && (opcode == OP_LOAD_PAT) && col_ok)
        begin
            pat_next[col_idx] = char_value;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg;
        found_next     = found_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && (opcode == OP_SEARCH))
                begin
                    state_next = S_ROWS;
                    cnt_next   = '0;
                    len_next   = pattern_length;
                    hit_next   = 1'b0;
                end
            end
            S_ROWS:
            begin
                hit_next = hit_reg | line_hit;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_COLS;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_COLS:
            begin
                hit_next = hit_reg | line_hit;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_HOLD;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_HOLD:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    found_next     = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        found_reg <= found_next;
        pat_reg   <= pat_next;
    end

    assign res_valid = res_valid_reg;
    assign found     = found_reg;

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (opcode == OP_SEARCH)) |=> (state_reg == S_ROWS && cnt_reg == '0))
        else $error("search transfer did not start a row scan");

    a_rows_then_cols: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROWS && cnt_reg == CNT_LAST) |=> (state_reg == S_COLS))
        else $error("row scan did not hand over to column scan");

    a_hold_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && (!res_valid || res_ready)) |=> (res_valid && found == $past(hit_reg)))
        else $error("finished search not moved to the output register");

    a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && len_reg == '0) |-> hit_reg)
        else $error("empty pattern did not match");

    a_long_misses: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD && 32'(len_reg) > GRID_SIDE) |-> !hit_reg)
        else $error("pattern longer than the grid side matched");

endmodule

`default_nettype wire
